### hdl/efsa_pkg.sv
// ----------------------------------------------------------------------------
// efsa_pkg: shared constants for the earliest free server assigner
// Field widths, register reset value and the saturation limit.
// ----------------------------------------------------------------------------
package efsa_pkg;

    localparam int CFG_W         = 5;   // desks_in_use register
    localparam int SVC_W         = 16;  // service_time
    localparam int COST_W        = 16;  // job_cost
    localparam int DESK_W        = 4;   // chosen_desk
    localparam int ACC_W         = 32;  // time and cost accumulators
    localparam int MAX_DESKS_DEF = 16;

    localparam logic [CFG_W-1:0] DESKS_RESET = CFG_W'(16);
    localparam logic [ACC_W-1:0] ACC_MAX     = {ACC_W{1'b1}};

endpackage

### hdl/efsa_chan_if.sv
// ----------------------------------------------------------------------------
// efsa channel interfaces
// Valid/ready channels for job words in and result words out.
// ----------------------------------------------------------------------------
interface efsa_job_if;
    logic                      valid;
    logic                      ready;
    logic [efsa_pkg::SVC_W-1:0]  service_time;
    logic [efsa_pkg::COST_W-1:0] job_cost;
    logic                      last_customer;

    modport source (output valid, service_time, job_cost, last_customer, input ready);
    modport sink   (input valid, service_time, job_cost, last_customer, output ready);
endinterface

interface efsa_res_if;
    logic                        valid;
    logic                        ready;
    logic [efsa_pkg::DESK_W-1:0] chosen_desk;
    logic [efsa_pkg::ACC_W-1:0]  start_time;
    logic [efsa_pkg::ACC_W-1:0]  finish_time;
    logic [efsa_pkg::ACC_W-1:0]  desk_cost_total;
    logic [efsa_pkg::ACC_W-1:0]  makespan;
    logic                        batch_final;
    logic                        saturated;

    modport source (output valid, chosen_desk, start_time, finish_time, desk_cost_total,
                    makespan, batch_final, saturated, input ready);
    modport sink   (input valid, chosen_desk, start_time, finish_time, desk_cost_total,
                    makespan, batch_final, saturated, output ready);
endinterface

### hdl/efsa_argmin.sv
// ----------------------------------------------------------------------------
// efsa_argmin: minimum busy-until search
// Balanced compare tree over the active desks; ties go to the lower desk.
// ----------------------------------------------------------------------------
module efsa_argmin #(
    parameter int MAX_DESKS = efsa_pkg::MAX_DESKS_DEF,
    parameter int IDX_W     = (MAX_DESKS > 1) ? $clog2(MAX_DESKS) : 1
) (
    input  logic [efsa_pkg::ACC_W-1:0] i_busy [MAX_DESKS],
    input  logic [MAX_DESKS-1:0]       i_active,
    output logic [IDX_W-1:0]           o_idx,
    output logic [efsa_pkg::ACC_W-1:0] o_val
);
    import efsa_pkg::*;

    localparam int LEAVES = 1 << IDX_W;
    localparam int NODES  = 2 * LEAVES - 1;

    logic [ACC_W-1:0] node_val [NODES];
    logic [IDX_W-1:0] node_idx [NODES];
    logic             node_ok  [NODES];

    // leaves: desks past MAX_DESKS never take part
    for (genvar l = 0; l < LEAVES; l++) begin : g_leaf
        if (l < MAX_DESKS) begin : g_real
            assign node_val[LEAVES-1+l] = i_busy[l];
            assign node_ok[LEAVES-1+l]  = i_active[l];
        end else begin : g_pad
            assign node_val[LEAVES-1+l] = '0;
            assign node_ok[LEAVES-1+l]  = 1'b0;
        end
        assign node_idx[LEAVES-1+l] = IDX_W'(l);
    end

    // inner nodes: left child holds the lower indices, so it wins ties
    for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
        logic take_left;
        assign take_left = node_ok[2*n+1] &&
                           (!node_ok[2*n+2] || (node_val[2*n+1] <= node_val[2*n+2]));
        assign node_val[n] = take_left ? node_val[2*n+1] : node_val[2*n+2];
        assign node_idx[n] = take_left ? node_idx[2*n+1] : node_idx[2*n+2];
        assign node_ok[n]  = node_ok[2*n+1] || node_ok[2*n+2];
    end

    assign o_idx = node_idx[0];
    assign o_val = node_val[0];

endmodule

### hdl/earliest_free_server_assigner_unit.sv
// ----------------------------------------------------------------------------
// earliest_free_server_assigner_unit: greedy desk assignment
// Picks the earliest free active desk for each job, books the job on it and
// reports start, finish, desk cost total and the running makespan.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake         | word
//  ---------+-----+-------------------+------------------------------------------
//  i_job    | in  | valid/ready       | service_time, job_cost, last_customer
//  o_res    | out | valid/ready       | chosen_desk, start/finish_time, cost total,
//           |     |                   | makespan, batch_final, saturated
//  i_cfg_*  | in  | write enable only | desks_in_use (5 bits)
//
//  One job word per cycle sustained while o_res is not stalled; each word passes
//  the input register, then the result register, before it shows on o_res.
//  The argmin tree over the desk registers plus one 32-bit adder sets the
//  cycle time. The desk state is updated at the same edge that loads the
//  result register, so the next job sees it immediately.
//  Reset clears all desk totals and the makespan and sets 16 desks in use.
//  A stalled o_res holds its word; i_job keeps taking a word while the input
//  register is empty or drains into the result register in that cycle.
//
module earliest_free_server_assigner_unit #(
    parameter int MAX_DESKS = efsa_pkg::MAX_DESKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [efsa_pkg::CFG_W-1:0]  i_cfg_wdata,
    efsa_job_if.sink                    i_job,
    efsa_res_if.source                  o_res
);
    import efsa_pkg::*;

    localparam int IDX_W = (MAX_DESKS > 1) ? $clog2(MAX_DESKS) : 1;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_desks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desks <= DESKS_RESET;
        end else if (i_cfg_we) begin
            r_desks <= i_cfg_wdata;
        end
    end

    // desk 0 always takes part (a count of zero acts as one); desks past
    // MAX_DESKS do not exist, which clamps large counts
    logic [MAX_DESKS-1:0] w_active;
    for (genvar d = 0; d < MAX_DESKS; d++) begin : g_active
        assign w_active[d] = (d == 0) || (32'(d) < 32'(r_desks));
    end

    // ---------------- input register ----------------
    logic              r_in_valid;
    logic [SVC_W-1:0]  r_svc;
    logic [COST_W-1:0] r_cost;
    logic              r_last;
    logic              w_adv;      // input word moves into the result register
    logic              r_out_valid;

    assign w_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_job.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_job.ready) begin
            r_in_valid <= i_job.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job.valid && i_job.ready) begin
            r_svc  <= i_job.service_time;
            r_cost <= i_job.job_cost;
            r_last <= i_job.last_customer;
        end
    end

    // ---------------- desk state and choice ----------------
    logic [ACC_W-1:0] r_busy [MAX_DESKS];
    logic [ACC_W-1:0] r_csum [MAX_DESKS];
    logic [ACC_W-1:0] r_max;

    logic [IDX_W-1:0] w_pick;
    logic [ACC_W-1:0] w_start;

    efsa_argmin #(
        .MAX_DESKS (MAX_DESKS),
        .IDX_W     (IDX_W)
    ) u_argmin (
        .i_busy   (r_busy),
        .i_active (w_active),
        .o_idx    (w_pick),
        .o_val    (w_start)
    );

    // saturating adds on the chosen desk
    logic [ACC_W:0]   w_fin_sum, w_tot_sum;
    logic [ACC_W-1:0] w_finish, w_total, w_span;
    logic             w_clip;

    assign w_fin_sum = {1'b0, w_start} + (ACC_W+1)'(r_svc);
    assign w_tot_sum = {1'b0, r_csum[w_pick]} + (ACC_W+1)'(r_cost);
    assign w_finish  = w_fin_sum[ACC_W] ? ACC_MAX : w_fin_sum[ACC_W-1:0];
    assign w_total   = w_tot_sum[ACC_W] ? ACC_MAX : w_tot_sum[ACC_W-1:0];
    assign w_clip    = w_fin_sum[ACC_W] || w_tot_sum[ACC_W];
    assign w_span    = (w_finish > r_max) ? w_finish : r_max;

    // book the job; the last job of a batch wipes everything for the next one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DESKS; d++) begin
                r_busy[d] <= '0;
                r_csum[d] <= '0;
            end
            r_max <= '0;
        end else if (w_adv) begin
            if (r_last) begin
                for (int d = 0; d < MAX_DESKS; d++) begin
                    r_busy[d] <= '0;
                    r_csum[d] <= '0;
                end
                r_max <= '0;
            end else begin
                r_busy[w_pick] <= w_finish;
                r_csum[w_pick] <= w_total;
                r_max          <= w_span;
            end
        end
    end

    // ---------------- result register ----------------
    logic [DESK_W-1:0] r_desk;
    logic [ACC_W-1:0]  r_start, r_finish, r_total, r_span;
    logic              r_final, r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_desk   <= DESK_W'(w_pick);
            r_start  <= w_start;
            r_finish <= w_finish;
            r_total  <= w_total;
            r_span   <= w_span;
            r_final  <= r_last;
            r_sat    <= w_clip;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.chosen_desk     = r_desk;
    assign o_res.start_time      = r_start;
    assign o_res.finish_time     = r_finish;
    assign o_res.desk_cost_total = r_total;
    assign o_res.makespan        = r_span;
    assign o_res.batch_final     = r_final;
    assign o_res.saturated       = r_sat;

endmodule

### hdl/efsa_checker.sv
// ----------------------------------------------------------------------------
// efsa_checker: port-level checks for the assigner
// Watches the result channel over time; bound to the top level below.
// ----------------------------------------------------------------------------
module efsa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [efsa_pkg::DESK_W-1:0] i_desk,
    input logic [efsa_pkg::ACC_W-1:0]  i_start,
    input logic [efsa_pkg::ACC_W-1:0]  i_finish,
    input logic [efsa_pkg::ACC_W-1:0]  i_span,
    input logic                        i_final
);
    import efsa_pkg::*;

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_finish) &&
                                           $stable(i_desk) && $stable(i_span)))
        else $error("result word changed while stalled");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // finish never precedes start, makespan covers the finish
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_finish >= i_start) && (i_span >= i_finish))
        else $error("finish or makespan out of order");

    // first job after a batch end lands on desk 0 at time 0
    a_newbatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_final) |=>
            (!i_out_valid || (i_start == '0 && i_desk == '0)))
        else $error("new batch did not start from cleared desks");

endmodule

bind earliest_free_server_assigner_unit efsa_checker u_efsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_desk      (o_res.chosen_desk),
    .i_start     (o_res.start_time),
    .i_finish    (o_res.finish_time),
    .i_span      (o_res.makespan),
    .i_final     (o_res.batch_final)
);
